@@ rtl/core/x86_16bit_execute_unit_assert.svh @@
// ============================================================================
// x86 execute unit assertion macros
// Concurrent assertion shorthands used by the execute unit top level. Define
// ASSERT_OFF to compile them away.
// ============================================================================
`ifndef X86_16BIT_EXECUTE_UNIT_ASSERT_SVH
`define X86_16BIT_EXECUTE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising clock edge outside reset.
`define X86E_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define X86E_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define X86E_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define X86E_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/x86e_pkg.sv @@
// ============================================================================
// x86 execute unit package
// Shared constants, operation codes, clock-estimate tables and the structs
// that travel between the execute unit's modules.
// ============================================================================
package x86e_pkg;

   // Data memory geometry. The memory is split into an even and an odd byte
   // bank so that a word at any address touches each bank once.
   localparam int unsigned MEM_BYTES = 65536;
   localparam int unsigned ADDR_W    = $clog2(MEM_BYTES);
   localparam int unsigned ROWS      = MEM_BYTES / 2;
   localparam int unsigned ROW_W     = ADDR_W - 1;
   localparam int unsigned NUM_REGS  = 8;

   // Operation codes.
   localparam logic [2:0] OP_MOV  = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_CMP  = 3'd3;
   localparam logic [2:0] OP_JNE  = 3'd4;
   localparam logic [2:0] OP_LOOP = 3'd5;

   // Source operand kinds.
   localparam logic [1:0] SRC_REG = 2'd0;
   localparam logic [1:0] SRC_IMM = 2'd1;
   localparam logic [1:0] SRC_MEM = 2'd2;
   localparam logic [1:0] SRC_ALT = 2'd3;

   // Destination operand kinds.
   localparam logic DST_REG = 1'b0;
   localparam logic DST_MEM = 1'b1;

   // Address term codes.
   localparam logic [1:0] EA_NONE = 2'd0;
   localparam logic [1:0] EA_BX   = 2'd1;
   localparam logic [1:0] EA_BP   = 2'd2;
   localparam logic [1:0] EA_SI   = 2'd1;
   localparam logic [1:0] EA_DI   = 2'd2;

   // Word register codes.
   localparam logic [2:0] REG_AX = 3'd0;
   localparam logic [2:0] REG_CX = 3'd1;
   localparam logic [2:0] REG_DX = 3'd2;
   localparam logic [2:0] REG_BX = 3'd3;
   localparam logic [2:0] REG_BP = 3'd5;
   localparam logic [2:0] REG_SI = 3'd6;
   localparam logic [2:0] REG_DI = 3'd7;

   // Effective-address clock costs.
   localparam logic [4:0] CLK_EA_NEAR      = 5'd7;
   localparam logic [4:0] CLK_EA_NEAR_DISP = 5'd11;
   localparam logic [4:0] CLK_EA_FAR       = 5'd8;
   localparam logic [4:0] CLK_EA_FAR_DISP  = 5'd12;
   localparam logic [4:0] CLK_EA_ONE       = 5'd5;
   localparam logic [4:0] CLK_EA_ONE_DISP  = 5'd9;
   localparam logic [4:0] CLK_EA_DIRECT    = 5'd6;

   // Base clock costs.
   localparam logic [4:0] CLK_MOV_RR    = 5'd2;
   localparam logic [4:0] CLK_MOV_RI    = 5'd4;
   localparam logic [4:0] CLK_MOV_MI    = 5'd10;
   localparam logic [4:0] CLK_MOV_MR    = 5'd9;
   localparam logic [4:0] CLK_MOV_MR_AX = 5'd10;
   localparam logic [4:0] CLK_MOV_RM    = 5'd8;
   localparam logic [4:0] CLK_MOV_RM_AX = 5'd10;
   localparam logic [4:0] CLK_ADD_RR    = 5'd3;
   localparam logic [4:0] CLK_ADD_RI    = 5'd4;
   localparam logic [4:0] CLK_ADD_RM    = 5'd9;
   localparam logic [4:0] CLK_ADD_MR    = 5'd16;
   localparam logic [4:0] CLK_ADD_MI    = 5'd17;
   localparam logic [4:0] CLK_NONE      = 5'd0;

   // Instruction held between the accept cycle and the execute cycle.
   typedef struct packed {
      logic [2:0]        op;
      logic              dst_mem;
      logic [1:0]        src_kind;
      logic              wide;
      logic [2:0]        dst_reg;
      logic [2:0]        src_reg;
      logic [15:0]       imm;
      logic [ADDR_W-1:0] addr;
      logic [2:0]        len;
      logic [4:0]        clocks;
   } ex_stage_type;

   // Registers that feed the address adder.
   typedef struct packed {
      logic [15:0] bx;
      logic [15:0] bp;
      logic [15:0] si;
      logic [15:0] di;
   } addr_regs_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic              en;
      logic              wide;
      logic [ADDR_W-1:0] addr;
      logic [15:0]       data;
   } mem_wr_type;

   typedef struct packed {
      logic [15:0] next_ip;
      logic [4:0]  clocks;
      logic        zero;
      logic        sign;
      logic [15:0] result;
   } rsp_payload_type;

   // Effective-address cost from the address terms present.
   function automatic logic [4:0] ea_clocks(input logic [1:0] base,
                                            input logic [1:0] index,
                                            input logic       has_disp);
      logic       has_base;
      logic       has_index;
      logic [4:0] cost;
      has_base  = (base == EA_BX) || (base == EA_BP);
      has_index = (index == EA_SI) || (index == EA_DI);
      if (has_base && has_index) begin
         // bx+si and bp+di share a code value and are the faster pairs.
         if (base == index) begin
            cost = has_disp ? CLK_EA_NEAR_DISP : CLK_EA_NEAR;
         end else begin
            cost = has_disp ? CLK_EA_FAR_DISP : CLK_EA_FAR;
         end
      end else if (has_base || has_index) begin
         cost = has_disp ? CLK_EA_ONE_DISP : CLK_EA_ONE;
      end else begin
         cost = CLK_EA_DIRECT;
      end
      return cost;
   endfunction

   // Base cost by operation and operand form; src_kind is already normalized.
   function automatic logic [4:0] base_clocks(input logic [2:0] op,
                                              input logic       dst_mem,
                                              input logic [1:0] src_kind,
                                              input logic [2:0] dst_reg,
                                              input logic [2:0] src_reg);
      logic [4:0] cost;
      cost = CLK_NONE;
      if (op == OP_MOV) begin
         if (dst_mem) begin
            if (src_kind == SRC_IMM) begin
               cost = CLK_MOV_MI;
            end else begin
               cost = (src_reg == REG_AX) ? CLK_MOV_MR_AX : CLK_MOV_MR;
            end
         end else if (src_kind == SRC_MEM) begin
            cost = (dst_reg == REG_AX) ? CLK_MOV_RM_AX : CLK_MOV_RM;
         end else begin
            cost = (src_kind == SRC_IMM) ? CLK_MOV_RI : CLK_MOV_RR;
         end
      end else if (op == OP_ADD) begin
         if (dst_mem) begin
            cost = (src_kind == SRC_IMM) ? CLK_ADD_MI : CLK_ADD_MR;
         end else if (src_kind == SRC_MEM) begin
            cost = CLK_ADD_RM;
         end else begin
            cost = (src_kind == SRC_IMM) ? CLK_ADD_RI : CLK_ADD_RR;
         end
      end
      return cost;
   endfunction

endpackage

@@ rtl/core/x86e_if.sv @@
// ============================================================================
// x86 execute unit channels
// Valid/ready channels for decoded instructions and for execution results.
// ============================================================================
interface x86e_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic        dst_kind;
   logic [1:0]  src_kind;
   logic        wide;
   logic [2:0]  dst_reg;
   logic [2:0]  src_reg;
   logic [15:0] imm_value;
   logic [1:0]  ea_base;
   logic [1:0]  ea_index;
   logic [15:0] ea_disp;
   logic [2:0]  inst_length;

   modport source (
      output valid, op, dst_kind, src_kind, wide, dst_reg, src_reg, imm_value,
             ea_base, ea_index, ea_disp, inst_length,
      input  ready
   );
   modport sink (
      input  valid, op, dst_kind, src_kind, wide, dst_reg, src_reg, imm_value,
             ea_base, ea_index, ea_disp, inst_length,
      output ready
   );
endinterface

interface x86e_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] next_ip;
   logic [4:0]  clocks;
   logic        zero_out;
   logic        sign_out;
   logic [15:0] result_value;

   modport source (
      output valid, next_ip, clocks, zero_out, sign_out, result_value,
      input  ready
   );
   modport sink (
      input  valid, next_ip, clocks, zero_out, sign_out, result_value,
      output ready
   );
endinterface

@@ rtl/core/x86e_ram.sv @@
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered read data output.
// ============================================================================
module x86e_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/x86e_data_mem.sv @@
// ============================================================================
// x86 execute unit data memory
// Byte-addressed memory built from an even and an odd bank, with word access
// that wraps at the top of memory and a clearing pass after reset.
// ============================================================================
module x86e_data_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  x86e_pkg::mem_rd_type rd,
   input  x86e_pkg::mem_wr_type wr,
   output logic [15:0]          rd_data,
   output logic                 clear_busy
);

   logic [x86e_pkg::ROW_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic                       clr_busy_ff, clr_busy_in;
   logic                       rd_odd_ff, rd_odd_in;

   logic [x86e_pkg::ROW_W-1:0] rd_row, wr_row;
   logic                       rd_odd, wr_odd;
   logic [x86e_pkg::ROW_W-1:0] even_rd_addr, even_wr_addr, odd_wr_addr;
   logic                       even_we, odd_we;
   logic [7:0]                 even_wd, odd_wd;
   logic [7:0]                 even_q, odd_q;

   // A byte at an odd address sits in the odd bank; the byte after it is in
   // the even bank one row further on.
   assign rd_row       = rd.addr[x86e_pkg::ADDR_W-1:1];
   assign rd_odd       = rd.addr[0];
   assign even_rd_addr = rd_row + x86e_pkg::ROW_W'(rd_odd);
   assign wr_row       = wr.addr[x86e_pkg::ADDR_W-1:1];
   assign wr_odd       = wr.addr[0];

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end
      rd_odd_in = rd.en ? rd_odd : rd_odd_ff;
   end

   always_comb begin
      if (clr_busy_ff) begin
         even_we      = 1'b1;
         odd_we       = 1'b1;
         even_wr_addr = clr_cnt_ff;
         odd_wr_addr  = clr_cnt_ff;
         even_wd      = 8'h00;
         odd_wd       = 8'h00;
      end else begin
         even_we      = wr.en && (wr.wide || !wr_odd);
         odd_we       = wr.en && (wr.wide || wr_odd);
         even_wr_addr = wr_row + x86e_pkg::ROW_W'(wr_odd);
         odd_wr_addr  = wr_row;
         even_wd      = wr_odd ? wr.data[15:8] : wr.data[7:0];
         odd_wd       = wr_odd ? wr.data[7:0] : wr.data[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
      rd_odd_ff <= rd_odd_in;
   end

   x86e_ram #(
      .WIDTH (8),
      .DEPTH (x86e_pkg::ROWS)
   ) u_even_bank (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (even_wr_addr),
      .wr_data (even_wd),
      .rd_en   (rd.en),
      .rd_addr (even_rd_addr),
      .rd_data (even_q)
   );

   x86e_ram #(
      .WIDTH (8),
      .DEPTH (x86e_pkg::ROWS)
   ) u_odd_bank (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (odd_wr_addr),
      .wr_data (odd_wd),
      .rd_en   (rd.en),
      .rd_addr (rd_row),
      .rd_data (odd_q)
   );

   assign rd_data    = rd_odd_ff ? {even_q, odd_q} : {odd_q, even_q};
   assign clear_busy = clr_busy_ff;

endmodule

@@ rtl/core/x86e_exec.sv @@
// ============================================================================
// x86 execute unit architectural state and ALU
// Holds the general registers, IP and flags, executes one instruction per
// fire with the memory operand already read, and forms the memory write.
// ============================================================================
module x86e_exec (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  x86e_pkg::ex_stage_type    ex,
   input  logic [15:0]               mem_rd_data,
   output x86e_pkg::addr_regs_type   addr_regs,
   output x86e_pkg::mem_wr_type      mem_wr,
   output x86e_pkg::rsp_payload_type rsp
);

   logic [15:0] regs_ff [x86e_pkg::NUM_REGS];
   logic [15:0] regs_in [x86e_pkg::NUM_REGS];
   logic [15:0] ip_ff, ip_in;
   logic        zero_ff, zero_in;
   logic        sign_ff, sign_in;

   logic        is_alu, writes_back, sets_flags, taken;
   logic [15:0] ip_adv, ip_next, cx_dec;
   logic [15:0] dst_word, src_word, mem_val;
   logic [7:0]  dst_byte, src_byte;
   logic [15:0] dval, sval, sum, diff, raw, result;
   logic        res_zero, res_sign;

   assign is_alu      = (ex.op[2] == 1'b0);
   assign writes_back = is_alu && (ex.op != x86e_pkg::OP_CMP);
   assign sets_flags  = is_alu && (ex.op != x86e_pkg::OP_MOV);

   // Byte codes four to seven name the high halves of the first four words.
   always_comb begin
      dst_word = regs_ff[ex.dst_reg];
      src_word = regs_ff[ex.src_reg];
      dst_byte = ex.dst_reg[2] ? regs_ff[{1'b0, ex.dst_reg[1:0]}][15:8]
                               : regs_ff[{1'b0, ex.dst_reg[1:0]}][7:0];
      src_byte = ex.src_reg[2] ? regs_ff[{1'b0, ex.src_reg[1:0]}][15:8]
                               : regs_ff[{1'b0, ex.src_reg[1:0]}][7:0];
      mem_val  = ex.wide ? mem_rd_data : {8'h00, mem_rd_data[7:0]};

      if (ex.dst_mem) begin
         dval = mem_val;
      end else begin
         dval = ex.wide ? dst_word : {8'h00, dst_byte};
      end

      unique case (ex.src_kind)
         x86e_pkg::SRC_IMM: sval = ex.wide ? ex.imm : {8'h00, ex.imm[7:0]};
         x86e_pkg::SRC_MEM: sval = mem_val;
         default:           sval = ex.wide ? src_word : {8'h00, src_byte};
      endcase

      sum  = dval + sval;
      diff = dval - sval;
      unique case (ex.op)
         x86e_pkg::OP_MOV: raw = sval;
         x86e_pkg::OP_ADD: raw = sum;
         default:          raw = diff;
      endcase
      result   = ex.wide ? raw : {8'h00, raw[7:0]};
      res_zero = (result == 16'h0000);
      res_sign = ex.wide ? result[15] : result[7];
   end

   // Branches resolve against the IP already advanced past the instruction.
   always_comb begin
      ip_adv  = ip_ff + {13'd0, ex.len};
      cx_dec  = regs_ff[x86e_pkg::REG_CX] - 16'd1;
      taken   = ((ex.op == x86e_pkg::OP_JNE) && !zero_ff) ||
                ((ex.op == x86e_pkg::OP_LOOP) && (cx_dec != 16'h0000));
      ip_next = taken ? (ip_adv + ex.imm) : ip_adv;
   end

   always_comb begin
      regs_in = regs_ff;
      ip_in   = ip_ff;
      zero_in = zero_ff;
      sign_in = sign_ff;
      if (fire) begin
         ip_in = ip_next;
         if (sets_flags) begin
            zero_in = res_zero;
            sign_in = res_sign;
         end
         if (writes_back && (ex.dst_mem == x86e_pkg::DST_REG)) begin
            if (ex.wide) begin
               regs_in[ex.dst_reg] = result;
            end else if (ex.dst_reg[2]) begin
               regs_in[{1'b0, ex.dst_reg[1:0]}][15:8] = result[7:0];
            end else begin
               regs_in[{1'b0, ex.dst_reg[1:0]}][7:0] = result[7:0];
            end
         end
         if (ex.op == x86e_pkg::OP_LOOP) begin
            regs_in[x86e_pkg::REG_CX] = cx_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '{default: 16'h0000};
         ip_ff   <= '0;
         zero_ff <= 1'b0;
         sign_ff <= 1'b0;
      end else begin
         regs_ff <= regs_in;
         ip_ff   <= ip_in;
         zero_ff <= zero_in;
         sign_ff <= sign_in;
      end
   end

   always_comb begin
      addr_regs.bx = regs_ff[x86e_pkg::REG_BX];
      addr_regs.bp = regs_ff[x86e_pkg::REG_BP];
      addr_regs.si = regs_ff[x86e_pkg::REG_SI];
      addr_regs.di = regs_ff[x86e_pkg::REG_DI];

      mem_wr.en   = fire && writes_back && (ex.dst_mem == x86e_pkg::DST_MEM);
      mem_wr.wide = ex.wide;
      mem_wr.addr = ex.addr;
      mem_wr.data = result;

      rsp.next_ip = ip_next;
      rsp.clocks  = ex.clocks;
      rsp.zero    = sets_flags ? res_zero : zero_ff;
      rsp.sign    = sets_flags ? res_sign : sign_ff;
      rsp.result  = is_alu ? result : 16'h0000;
   end

endmodule

@@ rtl/core/x86_16bit_execute_unit.sv @@
// ============================================================================
// x86 16-bit execute unit
// Executes decoded mov/add/sub/cmp/jne/loop instructions
// against the general registers, IP, zero and sign flags and a byte memory.
// ============================================================================
//
//   Channel   Dir   Beat contents
//   req_chan  in    one decoded instruction (operation, operands, address)
//   rsp_chan  out   next IP, clock estimate, flags and result value
//
// Each instruction passes through an accept cycle, which forms the address and
// issues the data memory read, and an execute cycle, which writes back; a new
// beat is accepted only once the execute slot is free again.
// After reset the memory is cleared one row (two bytes) a cycle, covering all
// MEM_BYTES/2 = 32768 rows, with req_chan.ready low meanwhile.
// A full output register that is not taken holds the execute cycle and input.

`include "x86_16bit_execute_unit_assert.svh"

module x86_16bit_execute_unit (
   input  logic        clock,
   input  logic        reset,
   x86e_req_if.sink    req_chan,
   x86e_rsp_if.source  rsp_chan
);

   // Accept-stage signals.
   logic                    req_fire;
   logic                    clear_busy;
   logic                    is_alu, use_mem;
   logic [1:0]              src_norm;
   logic [15:0]             base_val, index_val, ea;
   logic [4:0]              inst_clocks;
   x86e_pkg::addr_regs_type addr_regs;
   x86e_pkg::mem_rd_type    mem_rd;
   x86e_pkg::mem_wr_type    mem_wr;
   logic [15:0]             mem_rd_data;

   // Execute stage and output register.
   logic                      ex_valid_ff, ex_valid_in;
   x86e_pkg::ex_stage_type    ex_ff, ex_in;
   logic                      ex_fire;
   x86e_pkg::rsp_payload_type rsp_calc;
   logic                      rsp_valid_ff, rsp_valid_in;
   x86e_pkg::rsp_payload_type rsp_ff, rsp_in;

   // A new beat may enter whenever the execute slot is free and the clearing pass
   // is done; the output register is decoupled by the execute-stage stall below.
   assign req_chan.ready = !ex_valid_ff && !clear_busy;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign ex_fire        = ex_valid_ff && (!rsp_valid_ff || rsp_chan.ready);

   // A memory source with a memory destination, and the unused source kind,
   // both fall back to a register source.
   always_comb begin
      if ((req_chan.src_kind == x86e_pkg::SRC_ALT) ||
          ((req_chan.dst_kind == x86e_pkg::DST_MEM) &&
           (req_chan.src_kind == x86e_pkg::SRC_MEM))) begin
         src_norm = x86e_pkg::SRC_REG;
      end else begin
         src_norm = req_chan.src_kind;
      end
      is_alu  = (req_chan.op[2] == 1'b0);
      use_mem = is_alu && ((req_chan.dst_kind == x86e_pkg::DST_MEM) ||
                           (src_norm == x86e_pkg::SRC_MEM));
   end

   // Effective address: base plus index plus displacement, wrapping at 64K.
   // The registers are current here because the previous instruction has
   // retired before this beat can be accepted.
   always_comb begin
      unique case (req_chan.ea_base)
         x86e_pkg::EA_BX: base_val = addr_regs.bx;
         x86e_pkg::EA_BP: base_val = addr_regs.bp;
         default:         base_val = 16'h0000;
      endcase
      unique case (req_chan.ea_index)
         x86e_pkg::EA_SI: index_val = addr_regs.si;
         x86e_pkg::EA_DI: index_val = addr_regs.di;
         default:         index_val = 16'h0000;
      endcase
      ea = req_chan.ea_disp + base_val + index_val;
   end

   // Clock estimate is known entirely from the decoded fields.
   always_comb begin
      inst_clocks = x86e_pkg::base_clocks(req_chan.op, req_chan.dst_kind, src_norm,
                                          req_chan.dst_reg, req_chan.src_reg);
      if (use_mem) begin
         inst_clocks = inst_clocks +
                       x86e_pkg::ea_clocks(req_chan.ea_base, req_chan.ea_index,
                                           (req_chan.ea_disp != 16'h0000));
      end
      if (!is_alu) begin
         inst_clocks = x86e_pkg::CLK_NONE;
      end
   end

   always_comb begin
      mem_rd.en   = req_fire;
      mem_rd.addr = ea[x86e_pkg::ADDR_W-1:0];
   end

   // Execute-stage capture.
   always_comb begin
      ex_valid_in = ex_valid_ff;
      ex_in       = ex_ff;
      if (ex_fire) begin
         ex_valid_in = 1'b0;
      end
      if (req_fire) begin
         ex_valid_in    = 1'b1;
         ex_in.op       = req_chan.op;
         ex_in.dst_mem  = req_chan.dst_kind;
         ex_in.src_kind = src_norm;
         ex_in.wide     = req_chan.wide;
         ex_in.dst_reg  = req_chan.dst_reg;
         ex_in.src_reg  = req_chan.src_reg;
         ex_in.imm      = req_chan.imm_value;
         ex_in.addr     = ea[x86e_pkg::ADDR_W-1:0];
         ex_in.len      = req_chan.inst_length;
         ex_in.clocks   = inst_clocks;
      end
   end

   // Output register: loads on an execute, empties when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ex_fire) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ex_ff  <= ex_in;
      rsp_ff <= rsp_in;
   end

   x86e_data_mem u_data_mem (
      .clock      (clock),
      .reset      (reset),
      .rd         (mem_rd),
      .wr         (mem_wr),
      .rd_data    (mem_rd_data),
      .clear_busy (clear_busy)
   );

   x86e_exec u_exec (
      .clock       (clock),
      .reset       (reset),
      .fire        (ex_fire),
      .ex          (ex_ff),
      .mem_rd_data (mem_rd_data),
      .addr_regs   (addr_regs),
      .mem_wr      (mem_wr),
      .rsp         (rsp_calc)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.next_ip      = rsp_ff.next_ip;
   assign rsp_chan.clocks       = rsp_ff.clocks;
   assign rsp_chan.zero_out     = rsp_ff.zero;
   assign rsp_chan.sign_out     = rsp_ff.sign;
   assign rsp_chan.result_value = rsp_ff.result;

   // An accepted beat always occupies the execute slot in the next cycle.
   `X86E_ASSERT_NEXT(a_accept_enters_execute, clock, reset, req_fire, ex_valid_ff)
   // No beat is taken while an instruction is still executing.
   `X86E_ASSERT_IMPLY(a_no_accept_in_execute, clock, reset, ex_valid_ff, !req_fire)
   // Memory write-back never collides with the clearing pass.
   `X86E_ASSERT_IMPLY(a_no_write_while_clear, clock, reset, mem_wr.en, !clear_busy)
   // An executed instruction is presented on the result channel next cycle.
   `X86E_ASSERT_NEXT(a_execute_gives_result, clock, reset, ex_fire, rsp_chan.valid)

endmodule
